// File: sv/assert_macros.svh
// Assertion macros used by the modulo pipeline of the ECMP next-hop selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Concurrent assertion on the default clock and reset of this project.
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: sv/ecmp_pkg.sv
// Shared widths, hash constants and payload types of the ECMP next-hop selector.
package ecmp_pkg;

  localparam int HashW        = 32;
  localparam int CountW       = 7;
  localparam int IndexW       = 6;
  localparam int RemW         = IndexW;
  localparam int DivStages    = 4;
  localparam int BitsPerStage = HashW / DivStages;

  localparam logic [CountW-1:0] MaxNextHops = 7'd64;

  localparam logic [HashW-1:0] MurC1    = 32'hcc9e2d51;
  localparam logic [HashW-1:0] MurC2    = 32'h1b873593;
  localparam logic [HashW-1:0] MixAdd   = 32'he6546b64;
  localparam logic [HashW-1:0] Fmix1    = 32'h85ebca6b;
  localparam logic [HashW-1:0] Fmix2    = 32'hc2b2ae35;
  localparam logic [HashW-1:0] KeyBytes = 32'd12;

  localparam logic [7:0] ProtoTcp  = 8'h06;
  localparam logic [7:0] ProtoUdp  = 8'h11;
  localparam logic [7:0] ProtoFc   = 8'hFC;
  localparam logic [7:0] ProtoFd   = 8'hFD;

  // Finished hash on its way into the modulo pipeline.
  typedef struct packed {
    logic [HashW-1:0]  hash;
    logic [CountW-1:0] divisor;
    logic              no_route;
  } mod_req_t;

endpackage

// File: sv/ecmp_mod_pipe.sv
// Pipelined remainder of the 32-bit hash by the next-hop count.
`include "assert_macros.svh"

module ecmp_mod_pipe import ecmp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mod_req_t          in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IndexW-1:0] next_hop_index_o,
  output logic              no_route_o,
  output logic [HashW-1:0]  hash_value_o
);

  typedef struct packed {
    logic [HashW-1:0]  hash;
    logic [RemW-1:0]   rem;
    logic [CountW-1:0] divisor;
    logic              no_route;
  } mod_stage_t;

  // Restoring division over one slice of dividend bits, most significant first.
  function automatic logic [RemW-1:0] div_step(input logic [RemW-1:0]         r,
                                               input logic [BitsPerStage-1:0] bits,
                                               input logic [CountW-1:0]       d);
    logic [CountW-1:0] t;
    logic [RemW-1:0]   acc;
    acc = r;
    for (int i = BitsPerStage - 1; i >= 0; i--) begin
      t = {acc, bits[i]};
      if (t >= d) begin
        t = t - d;
      end
      acc = t[RemW-1:0];
    end
    return acc;
  endfunction

  logic [DivStages-1:0] valid_q;
  logic [DivStages-1:0] valid_in;
  logic [DivStages:0]   rdy;
  mod_stage_t           stage_q  [DivStages];
  mod_stage_t           stage_in [DivStages];

  assign rdy[DivStages] = out_ready_i;
  assign valid_in[0]    = in_valid_i;
  assign stage_in[0]    = '{hash: in_req_i.hash, rem: '0, divisor: in_req_i.divisor,
                            no_route: in_req_i.no_route};

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    if (s > 0) begin : g_link
      assign valid_in[s] = valid_q[s-1];
      assign stage_in[s] = stage_q[s-1];
    end

    // A stage takes a new transaction when it is empty or its content moves on.
    assign rdy[s] = !valid_q[s] || rdy[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        valid_q[s] <= valid_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && valid_in[s]) begin
        stage_q[s].hash     <= stage_in[s].hash;
        stage_q[s].divisor  <= stage_in[s].divisor;
        stage_q[s].no_route <= stage_in[s].no_route;
        stage_q[s].rem      <= div_step(stage_in[s].rem,
            stage_in[s].hash[HashW-1-s*BitsPerStage -: BitsPerStage],
            stage_in[s].divisor);
      end
    end
  end

  assign in_ready_o       = rdy[0];
  assign out_valid_o      = valid_q[DivStages-1];
  assign hash_value_o     = stage_q[DivStages-1].hash;
  assign no_route_o       = stage_q[DivStages-1].no_route;
  assign next_hop_index_o = stage_q[DivStages-1].no_route ? '0 : stage_q[DivStages-1].rem;

  `ASSERT_DEF(a_rem_below_divisor,
      out_valid_o && !no_route_o |-> {1'b0, next_hop_index_o} < stage_q[DivStages-1].divisor,
      "remainder not below next-hop count")
  `ASSERT_DEF(a_no_route_matches_count,
      out_valid_o |-> no_route_o == (stage_q[DivStages-1].divisor == '0),
      "no-route flag disagrees with next-hop count")
  `ASSERT_DEF(a_last_stage_holds,
      out_valid_o && !out_ready_i |=> out_valid_o && $stable(stage_q[DivStages-1].rem),
      "stalled result changed")

endmodule

// File: sv/ecmp_hash_next_hop_select.sv
// ECMP next-hop selector: seeded MurmurHash3 x86_32 of the flow key, modulo hop count.
// Pipeline: 7 hash stages, then 4 modulo stages, from input transaction to result valid.
// Throughput: one transaction per cycle unless the output stalls; each stage has its own
// valid bit; per-stage ready lets bubbles fill as a finished result waits at the output.
// The modulo stages each resolve 8 quotient bits of the 32-bit hash by restoring division.
// Reset clears all valid bits and sets hash_seed to 0.
module ecmp_hash_next_hop_select import ecmp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [HashW-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       src_ip_i,
  input  logic [31:0]       dst_ip_i,
  input  logic [7:0]        l4_protocol_i,
  input  logic [15:0]       src_port_i,
  input  logic [15:0]       dst_port_i,
  input  logic [CountW-1:0] next_hop_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IndexW-1:0] next_hop_index_o,
  output logic              no_route_o,
  output logic [HashW-1:0]  hash_value_o
);

  localparam int HashStages = 7;

  typedef struct packed {
    logic [HashW-1:0]  h;
    logic [HashW-1:0]  k0;
    logic [HashW-1:0]  k1;
    logic [HashW-1:0]  k2;
    logic [CountW-1:0] divisor;
    logic              no_route;
  } hash_stage_t;

  function automatic logic [HashW-1:0] rotl15(input logic [HashW-1:0] v);
    return {v[HashW-16:0], v[HashW-1:HashW-15]};
  endfunction

  function automatic logic [HashW-1:0] mix_h(input logic [HashW-1:0] h,
                                             input logic [HashW-1:0] k);
    logic [HashW-1:0] t;
    t = h ^ k;
    t = {t[HashW-14:0], t[HashW-1:HashW-13]};
    return (t << 2) + t + MixAdd;
  endfunction

  logic [HashW-1:0]      hash_seed_q;
  logic [HashStages-1:0] valid_q;
  logic [HashStages-1:0] valid_in;
  logic [HashStages:0]   rdy;
  hash_stage_t           hs_q [HashStages];
  hash_stage_t           hs_d [HashStages];
  logic [HashW-1:0]      port_word;
  logic [CountW-1:0]     count_sat;
  logic [HashW-1:0]      fmix_t;
  logic [HashW-1:0]      h5_t;
  logic                  mod_valid;
  logic                  mod_ready;
  mod_req_t              mod_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_seed_q <= '0;
    end else if (cfg_we_i) begin
      hash_seed_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    port_word = '0;
    if (l4_protocol_i inside {ProtoTcp, ProtoUdp, ProtoFc, ProtoFd}) begin
      port_word = {dst_port_i, src_port_i};
    end
    count_sat = (next_hop_count_i > MaxNextHops) ? MaxNextHops : next_hop_count_i;
  end

  // Key multiplies first, then the three absorb rounds, then the finalizer.
  always_comb begin
    hs_d[0].h        = hash_seed_q;
    hs_d[0].k0       = src_ip_i * MurC1;
    hs_d[0].k1       = dst_ip_i * MurC1;
    hs_d[0].k2       = port_word * MurC1;
    hs_d[0].divisor  = count_sat;
    hs_d[0].no_route = (count_sat == '0);

    hs_d[1]    = hs_q[0];
    hs_d[1].k0 = rotl15(hs_q[0].k0) * MurC2;
    hs_d[1].k1 = rotl15(hs_q[0].k1) * MurC2;
    hs_d[1].k2 = rotl15(hs_q[0].k2) * MurC2;

    hs_d[2]   = hs_q[1];
    hs_d[2].h = mix_h(hs_q[1].h, hs_q[1].k0);

    hs_d[3]   = hs_q[2];
    hs_d[3].h = mix_h(hs_q[2].h, hs_q[2].k1);

    h5_t      = mix_h(hs_q[3].h, hs_q[3].k2) ^ KeyBytes;
    hs_d[4]   = hs_q[3];
    hs_d[4].h = h5_t ^ (h5_t >> 16);

    hs_d[5]   = hs_q[4];
    hs_d[5].h = hs_q[4].h * Fmix1;

    fmix_t    = hs_q[5].h ^ (hs_q[5].h >> 13);
    hs_d[6]   = hs_q[5];
    hs_d[6].h = fmix_t * Fmix2;
  end

  assign rdy[HashStages] = mod_ready;
  assign valid_in[0]     = in_valid_i;

  for (genvar s = 0; s < HashStages; s++) begin : g_stage
    if (s > 0) begin : g_link
      assign valid_in[s] = valid_q[s-1];
    end

    assign rdy[s] = !valid_q[s] || rdy[s+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        valid_q[s] <= valid_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && valid_in[s]) begin
        hs_q[s] <= hs_d[s];
      end
    end
  end

  assign in_ready_o       = rdy[0];
  assign mod_valid        = valid_q[HashStages-1];
  assign mod_req.hash     = hs_q[HashStages-1].h ^ (hs_q[HashStages-1].h >> 16);
  assign mod_req.divisor  = hs_q[HashStages-1].divisor;
  assign mod_req.no_route = hs_q[HashStages-1].no_route;

  ecmp_mod_pipe u_mod (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (mod_valid),
    .in_ready_o       (mod_ready),
    .in_req_i         (mod_req),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .next_hop_index_o (next_hop_index_o),
    .no_route_o       (no_route_o),
    .hash_value_o     (hash_value_o)
  );

endmodule
